// File: design/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types, codes and helpers for the websocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

   // frame event codes
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_MSG_DONE  = 3'd1;
   localparam logic [2:0] EV_FRAGMENT  = 3'd2;
   localparam logic [2:0] EV_CLOSE     = 3'd3;
   localparam logic [2:0] EV_PING      = 3'd4;
   localparam logic [2:0] EV_PONG      = 3'd5;
   localparam logic [2:0] EV_UNKNOWN   = 3'd6;
   localparam logic [2:0] EV_TRUNCATED = 3'd7;

   // opcodes
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // header field constants
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] MASK_LAST  = 3'd3;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       payload_kind;
      logic       byte_last;
      logic [2:0] frame_event;
      logic [3:0] frame_opcode;
   } wsfp_result_type;

   // text or binary frame
   function automatic logic is_data_op(input logic [3:0] op);
      is_data_op = (op == OP_TEXT) || (op == OP_BINARY);
   endfunction

   // event reported when a frame ends
   function automatic logic [2:0] end_event(input logic fin, input logic [3:0] op);
      if (is_data_op(op)) begin
         end_event = fin ? EV_MSG_DONE : EV_FRAGMENT;
      end else if (op == OP_CLOSE) begin
         end_event = EV_CLOSE;
      end else if (op == OP_PING) begin
         end_event = EV_PING;
      end else if (op == OP_PONG) begin
         end_event = EV_PONG;
      end else begin
         end_event = EV_UNKNOWN;
      end
   endfunction

endpackage

// File: design/wsfp_in_reg.sv
// ----------------------------------------------------------------------------
// wsfp_in_reg
// Input register holding one raw byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsfp_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_data,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte,
   output logic       held_eod
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       eod_ff;

   // hold while full and the parser does not take the request
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload loads whenever the register is free to take a request
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         byte_ff <= req_in_byte;
         eod_ff  <= req_end_of_data;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_eod   = eod_ff;

endmodule

// File: design/wsfp_parser.sv
// ----------------------------------------------------------------------------
// wsfp_parser
// Frame parse state and the per-byte header, length, key and unmask logic.
// ----------------------------------------------------------------------------
module wsfp_parser #(
   parameter int LENGTH_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               in_byte,
   input  logic                     eod,
   output logic                     has_result,
   output wsfp_pkg::wsfp_result_type result
);
   import wsfp_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0, PH_HDR1, PH_EXT16, PH_EXT64, PH_MASK, PH_PAYLOAD, PH_DISCARD
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             op_ff, op_in;
   logic                   mask_ff, mask_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic                   ovf_ff, ovf_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             midx_ff, midx_in;

   logic                   hdr_phase;
   logic                   len_done;
   logic                   done;
   logic                   restart;
   logic                   pass;
   logic                   ovf_new;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic [7:0]             key_byte;
   logic [7:0]             plain;

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      fin_in     = fin_ff;
      op_in      = op_ff;
      mask_in    = mask_ff;
      rem_in     = rem_ff;
      ovf_in     = ovf_ff;
      key_in     = key_ff;
      midx_in    = midx_ff;
      hdr_phase  = 1'b0;
      len_done   = 1'b0;
      done       = 1'b0;
      restart    = 1'b0;
      has_result = 1'b0;
      result     = '0;
      ovf_new    = ovf_ff | (|rem_ff[LENGTH_BITS-1 -: 8]);
      rem_dec    = (rem_ff == '0) ? '0 : rem_ff - LENGTH_BITS'(1);
      pass       = (is_data_op(op_ff) && fin_ff) || (op_ff == OP_PING);
      // key byte for the current rotation position
      case (midx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      plain = in_byte ^ key_byte;

      unique case (phase_ff)
         PH_HDR0: begin
            hdr_phase = 1'b1;
            fin_in    = in_byte[7];
            op_in     = in_byte[3:0];
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            hdr_phase = 1'b1;
            mask_in   = in_byte[7];
            rem_in    = '0;
            ovf_in    = 1'b0;
            cnt_in    = '0;
            if (in_byte[6:0] == LEN7_EXT16) begin
               phase_in = PH_EXT16;
            end else if (in_byte[6:0] == LEN7_EXT64) begin
               phase_in = PH_EXT64;
            end else begin
               rem_in   = LENGTH_BITS'(in_byte[6:0]);
               len_done = 1'b1;
            end
         end
         PH_EXT16, PH_EXT64: begin
            hdr_phase = 1'b1;
            rem_in    = {rem_ff[LENGTH_BITS-9:0], in_byte};
            ovf_in    = ovf_new;
            if (cnt_ff >= ((phase_ff == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
               if (ovf_new) begin
                  rem_in = '1;
               end
               len_done = 1'b1;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         PH_MASK: begin
            hdr_phase = 1'b1;
            key_in    = {key_ff[23:0], in_byte};
            if (cnt_ff >= MASK_LAST) begin
               cnt_in   = '0;
               phase_in = PH_PAYLOAD;
               midx_in  = '0;
               done     = (rem_ff == '0);
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         PH_PAYLOAD: begin
            midx_in = midx_ff + 2'd1;
            rem_in  = rem_dec;
            result.frame_opcode = op_ff;
            if (rem_dec == '0) begin
               has_result          = 1'b1;
               result.out_byte     = pass ? plain : 8'd0;
               result.byte_valid   = pass;
               result.payload_kind = pass && (op_ff == OP_PING);
               result.byte_last    = 1'b1;
               result.frame_event  = end_event(fin_ff, op_ff);
               if (eod) begin
                  restart = 1'b1;
               end else begin
                  phase_in = PH_DISCARD;
               end
            end else if (eod) begin
               has_result         = 1'b1;
               result.byte_last   = 1'b1;
               result.frame_event = EV_TRUNCATED;
               restart            = 1'b1;
            end else if (pass) begin
               has_result          = 1'b1;
               result.out_byte     = plain;
               result.byte_valid   = 1'b1;
               result.payload_kind = (op_ff == OP_PING);
            end
         end
         PH_DISCARD: begin
            restart = eod;
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      // length complete: go to the key or straight to the payload
      if (len_done) begin
         cnt_in = '0;
         if (mask_in) begin
            phase_in = PH_MASK;
         end else begin
            phase_in = PH_PAYLOAD;
            midx_in  = '0;
            done     = (rem_in == '0);
         end
      end

      // header byte results: empty frame end or early end of buffer
      if (hdr_phase) begin
         result.frame_opcode = op_in;
         if (done) begin
            has_result         = 1'b1;
            result.byte_last   = 1'b1;
            result.frame_event = end_event(fin_in, op_in);
            if (eod) begin
               restart = 1'b1;
            end else begin
               phase_in = PH_DISCARD;
            end
         end else if (eod) begin
            has_result         = 1'b1;
            result.byte_last   = 1'b1;
            result.frame_event = EV_TRUNCATED;
            restart            = 1'b1;
         end
      end

      // back to the start of a new buffer
      if (restart) begin
         phase_in = PH_HDR0;
         cnt_in   = '0;
         fin_in   = 1'b0;
         op_in    = '0;
         mask_in  = 1'b0;
         rem_in   = '0;
         ovf_in   = 1'b0;
         key_in   = '0;
         midx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         cnt_ff   <= '0;
         fin_ff   <= 1'b0;
         op_ff    <= '0;
         mask_ff  <= 1'b0;
         rem_ff   <= '0;
         ovf_ff   <= 1'b0;
         key_ff   <= '0;
         midx_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
         op_ff    <= op_in;
         mask_ff  <= mask_in;
         rem_ff   <= rem_in;
         ovf_ff   <= ovf_in;
         key_ff   <= key_in;
         midx_ff  <= midx_in;
      end
   end

endmodule

// File: design/wsfp_out_reg.sv
// ----------------------------------------------------------------------------
// wsfp_out_reg
// Result register driving the response channel.
// ----------------------------------------------------------------------------
module wsfp_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic                      load_valid,
   input  wsfp_pkg::wsfp_result_type load_data,
   output logic                      free,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output wsfp_pkg::wsfp_result_type rsp_data
);
   import wsfp_pkg::*;

   logic            valid_ff, valid_in;
   wsfp_result_type data_ff;

   // register can take a new result when empty or being drained
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = load_valid;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: design/websocket_frame_parser_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser_core
// Receive-side WebSocket frame decoder, one raw byte per request.
// ----------------------------------------------------------------------------
// Usage: the req channel carries the received buffer one byte per request,
// with req_end_of_data high on the buffer's last byte. The rsp channel
// returns zero or one result per request: unmasked payload bytes of final
// text/binary frames (payload_kind 0), ping payload bytes (payload_kind 1),
// and one end-of-frame event with byte_last high. Header bytes give no result
// unless they end the frame or the buffer; bytes after the frame give none.
// A request is first held in the input register, parsed combinationally from
// there, and its result is then loaded into the result register that drives
// rsp. Throughput is one byte per cycle while the receiver does not stall;
// the parse state update and key XOR are combinational between the registers.
// Reset (synchronous) empties both registers and returns the parser to
// waiting for the first header byte with the mask key cleared.
// When the receiver stalls, the result register holds and the input
// register keeps one more request; after that req_stall rises.
// ----------------------------------------------------------------------------
module websocket_frame_parser_core #(
   parameter int LENGTH_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_payload_kind,
   output logic       rsp_byte_last,
   output logic [2:0] rsp_frame_event,
   output logic [3:0] rsp_frame_opcode
);
   import wsfp_pkg::*;

   logic            held_valid;
   logic [7:0]      held_byte;
   logic            held_eod;
   logic            out_free;
   logic            advance;
   logic            has_result;
   wsfp_result_type result;
   wsfp_result_type rsp_data;

   // a held request moves on when the result register can take it
   assign advance = held_valid && out_free;

   wsfp_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_data (req_end_of_data),
      .advance         (advance),
      .held_valid      (held_valid),
      .held_byte       (held_byte),
      .held_eod        (held_eod)
   );

   wsfp_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (held_byte),
      .eod        (held_eod),
      .has_result (has_result),
      .result     (result)
   );

   wsfp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (has_result),
      .load_data  (result),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   assign rsp_out_byte     = rsp_data.out_byte;
   assign rsp_byte_valid   = rsp_data.byte_valid;
   assign rsp_payload_kind = rsp_data.payload_kind;
   assign rsp_byte_last    = rsp_data.byte_last;
   assign rsp_frame_event  = rsp_data.frame_event;
   assign rsp_frame_opcode = rsp_data.frame_opcode;

   // a ping echo byte always carries a payload byte
   a_kind_needs_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload_kind) |-> rsp_byte_valid)
      else $error("payload_kind set without a payload byte");

   // exactly the frame-ending result carries an event
   a_last_has_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_last == (rsp_frame_event != EV_NONE)))
      else $error("byte_last and frame_event disagree");

   // truncation never carries a payload byte
   a_trunc_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_frame_event == EV_TRUNCATED)) |-> !rsp_byte_valid)
      else $error("truncated result carries a payload byte");

   // input side stalls only when its register is full and output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (held_valid && rsp_valid && rsp_stall))
      else $error("request stalled without a blocked result");

endmodule
